// ===== rtl/rgb_ycbcr_pixel_converter_assert.svh =====
`ifndef RGB_YCBCR_PIXEL_CONVERTER_ASSERT_SVH
`define RGB_YCBCR_PIXEL_CONVERTER_ASSERT_SVH

// same-cycle implication, clocked on i_clk, off during reset
`define RYC_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error("ryc: same-cycle check failed");

// next-cycle implication, clocked on i_clk, off during reset
`define RYC_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error("ryc: next-cycle check failed");

`endif

// ===== rtl/ryc_pkg.sv =====
package ryc_pkg;

    localparam int unsigned PixW   = 8;
    localparam int unsigned FracW  = 16;
    localparam int unsigned CfgIdxW = 2;

    typedef enum logic [CfgIdxW-1:0] {
        REG_DIRECTION = 2'd0,
        REG_PACKING   = 2'd1
    } t_reg_idx;

    typedef logic [PixW-1:0]  t_byte;
    typedef logic signed [9:0]  t_op;
    typedef logic signed [18:0] t_coef;
    typedef logic signed [28:0] t_prod;
    typedef logic signed [30:0] t_sum;
    typedef logic signed [9:0]  t_frac_out;
    typedef logic signed [10:0] t_wide;

    localparam t_sum RoundHalf = t_sum'(32768);
    localparam t_op  ChromaMid = t_op'(128);

    // rows: Y, Cb, Cr; columns: R, G, B
    localparam t_coef FwdCoef [3][3] = '{
        '{ 19'sd19595,  19'sd38470,  19'sd7471 },
        '{-19'sd11059, -19'sd21709,  19'sd32768},
        '{ 19'sd32768, -19'sd27439, -19'sd5329 }
    };

    // rows: R, G, B; columns: Y, Cb-128, Cr-128
    localparam t_coef InvCoef [3][3] = '{
        '{ 19'sd0,  19'sd0,       19'sd91881},
        '{ 19'sd0, -19'sd22554, -19'sd46802},
        '{ 19'sd0,  19'sd116130,  19'sd0    }
    };

    function automatic t_byte clamp8(input t_wide v);
        t_byte res;
        if (v < 0) begin
            res = '0;
        end else if (v > t_wide'(255)) begin
            res = '1;
        end else begin
            res = v[PixW-1:0];
        end
        return res;
    endfunction

endpackage

// ===== rtl/ryc_if.sv =====
interface ryc_pix_in_if;
    logic             valid;
    logic             ready;
    ryc_pkg::t_byte   byte0;
    ryc_pkg::t_byte   byte1;
    ryc_pkg::t_byte   byte2;
    ryc_pkg::t_byte   byte3;
    logic             last_in;

    modport source (output valid, byte0, byte1, byte2, byte3, last_in, input ready);
    modport sink   (input valid, byte0, byte1, byte2, byte3, last_in, output ready);
endinterface

interface ryc_pix_out_if;
    logic             valid;
    logic             ready;
    ryc_pkg::t_byte   out0;
    ryc_pkg::t_byte   out1;
    ryc_pkg::t_byte   out2;
    ryc_pkg::t_byte   out3;
    logic             last_out;

    modport source (output valid, out0, out1, out2, out3, last_out, input ready);
    modport sink   (input valid, out0, out1, out2, out3, last_out, output ready);
endinterface

interface ryc_cfg_if;
    logic                              valid;
    logic                              ready;
    logic [ryc_pkg::CfgIdxW-1:0]       reg_index;
    logic                              wr_data;

    modport source (output valid, reg_index, wr_data, input ready);
    modport sink   (input valid, reg_index, wr_data, output ready);
endinterface

// ===== rtl/rgb_ycbcr_pixel_converter.sv =====
// channel   role    payload
// i_pix     sink    byte0..byte3, last_in
// o_pix     source  out0..out3, last_out
// i_cfg     sink    reg_index (0 direction, 1 packing), wr_data
//
// four register stages: operand select, multiply, sum and round, offset and clamp
// one item per cycle sustained while o_pix.ready is high; an item passes the stages in order to o_pix.valid
// a stage moves on when the next stage is empty or moving, so bubbles fill under a stall
// i_rst_n is synchronous, active low; it empties the pipeline and clears both registers
// i_cfg.ready is always high; the registers take effect on the next accepted item

`include "rgb_ycbcr_pixel_converter_assert.svh"

module rgb_ycbcr_pixel_converter (
    input  logic          i_clk,
    input  logic          i_rst_n,
    ryc_pix_in_if.sink    i_pix,
    ryc_pix_out_if.source o_pix,
    ryc_cfg_if.sink       i_cfg
);

    typedef struct packed {
        logic           dir;
        logic           pack;
        ryc_pkg::t_op   op0;
        ryc_pkg::t_op   op1;
        ryc_pkg::t_op   op2;
        ryc_pkg::t_byte alpha;
        logic           last;
    } t_s1;

    typedef struct packed {
        logic           dir;
        logic           pack;
        ryc_pkg::t_byte luma;
        ryc_pkg::t_byte alpha;
        logic           last;
    } t_side;

    logic r_direction, r_packing;

    logic r_v1, r_v2, r_v3, r_v4;
    logic en1, en2, en3, en4;

    t_s1   r_s1, n_s1;
    t_side r_side2, r_side3;
    ryc_pkg::t_prod     r_p [3][3];
    ryc_pkg::t_prod     n_p [3][3];
    ryc_pkg::t_frac_out r_q [3];
    ryc_pkg::t_frac_out n_q [3];
    ryc_pkg::t_byte     n_res [3];
    ryc_pkg::t_byte     r_out0, r_out1, r_out2, r_out3, n_out0, n_out1, n_out2, n_out3;
    logic               r_last4;

    // configuration
    assign i_cfg.ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_direction <= 1'b0;
            r_packing   <= 1'b0;
        end else if (i_cfg.valid) begin
            if (i_cfg.reg_index == ryc_pkg::REG_DIRECTION) begin
                r_direction <= i_cfg.wr_data;
            end else if (i_cfg.reg_index == ryc_pkg::REG_PACKING) begin
                r_packing <= i_cfg.wr_data;
            end
        end
    end

    // stage enables
    assign en4 = !r_v4 || o_pix.ready;
    assign en3 = !r_v3 || en4;
    assign en2 = !r_v2 || en3;
    assign en1 = !r_v1 || en2;
    assign i_pix.ready = en1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
            r_v3 <= 1'b0;
            r_v4 <= 1'b0;
        end else begin
            if (en1) r_v1 <= i_pix.valid;
            if (en2) r_v2 <= r_v1;
            if (en3) r_v3 <= r_v2;
            if (en4) r_v4 <= r_v3;
        end
    end

    // stage 1: operand select
    always_comb begin
        n_s1.dir   = r_direction;
        n_s1.pack  = r_packing;
        n_s1.last  = i_pix.last_in;
        n_s1.op0   = ryc_pkg::t_op'({2'b00, i_pix.byte0});
        n_s1.op1   = ryc_pkg::t_op'({2'b00, i_pix.byte1});
        n_s1.op2   = ryc_pkg::t_op'({2'b00, i_pix.byte2});
        n_s1.alpha = i_pix.byte3;
        if (r_direction) begin
            if (r_packing) begin
                n_s1.op0   = ryc_pkg::t_op'({2'b00, i_pix.byte3});
                n_s1.op1   = ryc_pkg::t_op'({2'b00, i_pix.byte0}) - ryc_pkg::ChromaMid;
                n_s1.op2   = ryc_pkg::t_op'({2'b00, i_pix.byte1}) - ryc_pkg::ChromaMid;
                n_s1.alpha = i_pix.byte2;
            end else begin
                n_s1.op1 = ryc_pkg::t_op'({2'b00, i_pix.byte1}) - ryc_pkg::ChromaMid;
                n_s1.op2 = ryc_pkg::t_op'({2'b00, i_pix.byte2}) - ryc_pkg::ChromaMid;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (en1) r_s1 <= n_s1;
    end

    // stage 2: products
    always_comb begin
        for (int row = 0; row < 3; row++) begin
            n_p[row][0] = r_s1.op0 * (r_s1.dir ? ryc_pkg::InvCoef[row][0]
                                               : ryc_pkg::FwdCoef[row][0]);
            n_p[row][1] = r_s1.op1 * (r_s1.dir ? ryc_pkg::InvCoef[row][1]
                                               : ryc_pkg::FwdCoef[row][1]);
            n_p[row][2] = r_s1.op2 * (r_s1.dir ? ryc_pkg::InvCoef[row][2]
                                               : ryc_pkg::FwdCoef[row][2]);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en2) begin
            r_p <= n_p;
            r_side2.dir   <= r_s1.dir;
            r_side2.pack  <= r_s1.pack;
            r_side2.luma  <= r_s1.op0[ryc_pkg::PixW-1:0];
            r_side2.alpha <= r_s1.alpha;
            r_side2.last  <= r_s1.last;
        end
    end

    // stage 3: sum, round, floor shift
    always_comb begin
        for (int row = 0; row < 3; row++) begin
            n_q[row] = ryc_pkg::t_frac_out'((ryc_pkg::t_sum'(r_p[row][0])
                                            + ryc_pkg::t_sum'(r_p[row][1])
                                            + ryc_pkg::t_sum'(r_p[row][2])
                                            + ryc_pkg::RoundHalf) >>> ryc_pkg::FracW);
        end
    end

    always_ff @(posedge i_clk) begin
        if (en3) begin
            r_q     <= n_q;
            r_side3 <= r_side2;
        end
    end

    // stage 4: offset, clamp, byte order
    always_comb begin
        for (int row = 0; row < 3; row++) begin
            if (r_side3.dir) begin
                n_res[row] = ryc_pkg::clamp8(ryc_pkg::t_wide'(r_q[row])
                                             + ryc_pkg::t_wide'({3'b000, r_side3.luma}));
            end else if (row == 0) begin
                n_res[row] = ryc_pkg::clamp8(ryc_pkg::t_wide'(r_q[row]));
            end else begin
                n_res[row] = ryc_pkg::clamp8(ryc_pkg::t_wide'(r_q[row])
                                             + ryc_pkg::t_wide'(ryc_pkg::ChromaMid));
            end
        end
        if (!r_side3.dir && r_side3.pack) begin
            n_out0 = n_res[1];
            n_out1 = n_res[2];
            n_out2 = r_side3.alpha;
            n_out3 = n_res[0];
        end else begin
            n_out0 = n_res[0];
            n_out1 = n_res[1];
            n_out2 = n_res[2];
            n_out3 = r_side3.alpha;
        end
    end

    always_ff @(posedge i_clk) begin
        if (en4) begin
            r_out0  <= n_out0;
            r_out1  <= n_out1;
            r_out2  <= n_out2;
            r_out3  <= n_out3;
            r_last4 <= r_side3.last;
        end
    end

    assign o_pix.valid    = r_v4;
    assign o_pix.out0     = r_out0;
    assign o_pix.out1     = r_out1;
    assign o_pix.out2     = r_out2;
    assign o_pix.out3     = r_out3;
    assign o_pix.last_out = r_last4;

    `RYC_ASSERT_NOW(a_full_stall_blocks_input, r_v1 && r_v2 && r_v3 && r_v4 && !o_pix.ready, !i_pix.ready)
    `RYC_ASSERT_NEXT(a_item_moves_into_gap, r_v1 && !r_v2, r_v2)
    `RYC_ASSERT_NOW(a_inverse_luma_column_zero, r_v2 && r_side2.dir, r_p[0][0] == '0 && r_p[1][0] == '0 && r_p[2][0] == '0)
    `RYC_ASSERT_NEXT(a_output_drains_when_taken, r_v4 && o_pix.ready && !r_v3, !r_v4)

endmodule

// ===== tb/rgb_ycbcr_pixel_converter_tb.sv =====
module rgb_ycbcr_pixel_converter_tb;

    // conversion weights, scaled by 2^16
    localparam int KYR      = 19595;
    localparam int KYG      = 38470;
    localparam int KYB      = 7471;
    localparam int KCbR     = 11059;
    localparam int KCbG     = 21709;
    localparam int KHalf    = 32768;
    localparam int KCrG     = 27439;
    localparam int KCrB     = 5329;
    localparam int KRCr     = 91881;
    localparam int KBCb     = 116130;
    localparam int KGCr     = 46802;
    localparam int KGCb     = 22554;
    localparam int RoundAdd = 32768;
    localparam int FracBits = 16;
    localparam int ChromaOff = 128;

    localparam logic [ryc_pkg::CfgIdxW-1:0] RegSpareLo = 2'd2;
    localparam logic [ryc_pkg::CfgIdxW-1:0] RegSpareHi = 2'd3;

    localparam int CycleLimit  = 400000;
    localparam int HoldCycles  = 300;
    localparam int PhaseItems  = 200;
    localparam int NumPhases   = 7;
    localparam int TailCycles  = 16;
    localparam int NumDirVecs  = 21;

    typedef struct packed {
        ryc_pkg::t_byte b0;
        ryc_pkg::t_byte b1;
        ryc_pkg::t_byte b2;
        ryc_pkg::t_byte b3;
        logic           last;
    } t_pix;

    typedef struct packed {
        logic dir;
        logic pk;
        t_pix px;
        logic typed;
        t_pix res;
    } t_vec;

    // dir, pk, pixel in, typed, pixel out (zero where the predictor decides)
    localparam t_vec DirVecs [NumDirVecs] = '{
        {1'b0, 1'b0, 8'h00, 8'h00, 8'h00, 8'h00, 1'b0, 1'b1, 8'h00, 8'h80, 8'h80, 8'h00, 1'b0},
        {1'b0, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'h80, 8'h80, 8'hFF, 1'b1},
        {1'b0, 1'b0, 8'h80, 8'h80, 8'h80, 8'hC3, 1'b0, 1'b1, 8'h80, 8'h80, 8'h80, 8'hC3, 1'b0},
        {1'b0, 1'b0, 8'hFF, 8'h00, 8'h00, 8'h5A, 1'b0, 1'b0, 33'd0},
        {1'b0, 1'b0, 8'h00, 8'hFF, 8'h00, 8'hA5, 1'b1, 1'b0, 33'd0},
        {1'b0, 1'b0, 8'h00, 8'h00, 8'hFF, 8'h3C, 1'b0, 1'b0, 33'd0},
        {1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h77, 1'b1, 1'b1, 8'h80, 8'h80, 8'h77, 8'h00, 1'b1},
        {1'b0, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h01, 1'b0, 1'b1, 8'h80, 8'h80, 8'h01, 8'hFF, 1'b0},
        {1'b0, 1'b1, 8'hFF, 8'h00, 8'hFF, 8'hEE, 1'b0, 1'b0, 33'd0},
        {1'b1, 1'b0, 8'h00, 8'h80, 8'h80, 8'h12, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h12, 1'b0},
        {1'b1, 1'b0, 8'hFF, 8'h80, 8'h80, 8'h34, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'h34, 1'b1},
        {1'b1, 1'b0, 8'h00, 8'h00, 8'h00, 8'hFF, 1'b0, 1'b0, 33'd0},
        {1'b1, 1'b0, 8'hFF, 8'hFF, 8'hFF, 8'h00, 1'b0, 1'b0, 33'd0},
        {1'b1, 1'b0, 8'h80, 8'hFF, 8'h00, 8'h99, 1'b1, 1'b0, 33'd0},
        {1'b1, 1'b0, 8'h80, 8'h00, 8'hFF, 8'h66, 1'b0, 1'b0, 33'd0},
        {1'b1, 1'b1, 8'h80, 8'h80, 8'h5B, 8'h00, 1'b0, 1'b1, 8'h00, 8'h00, 8'h00, 8'h5B, 1'b0},
        {1'b1, 1'b1, 8'h80, 8'h80, 8'hA4, 8'hFF, 1'b1, 1'b1, 8'hFF, 8'hFF, 8'hFF, 8'hA4, 1'b1},
        {1'b1, 1'b1, 8'h00, 8'h00, 8'hC0, 8'h80, 1'b0, 1'b0, 33'd0},
        {1'b1, 1'b1, 8'hFF, 8'hFF, 8'h3F, 8'h80, 1'b0, 1'b0, 33'd0},
        {1'b1, 1'b1, 8'hFF, 8'h00, 8'h00, 8'hFF, 1'b1, 1'b0, 33'd0},
        {1'b0, 1'b0, 8'hAA, 8'h55, 8'hF0, 8'h0F, 1'b0, 1'b0, 33'd0}
    };

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    ryc_pix_in_if  pix_in ();
    ryc_pix_out_if pix_out ();
    ryc_cfg_if     cfg ();

    rgb_ycbcr_pixel_converter i_dut (
        .i_clk   (clk),
        .i_rst_n (rst_n),
        .i_pix   (pix_in),
        .o_pix   (pix_out),
        .i_cfg   (cfg)
    );

    t_pix expect_q [$];
    logic dir_q = 1'b0;
    logic pk_q  = 1'b0;
    bit   steady = 1'b0;
    bit   hold_off_req = 1'b0;
    int   fail_count = 0;
    int   pixels_sent = 0;
    int   results_seen = 0;
    int   settings_count = 0;
    int   cycle_count = 0;

    always begin
        #2 clk = 1'b1;
        #2 clk = 1'b0;
    end

    function automatic ryc_pkg::t_byte sat8(int v);
        if (v < 0) begin
            return 8'd0;
        end else if (v > 255) begin
            return 8'd255;
        end
        return ryc_pkg::t_byte'(v);
    endfunction

    function automatic t_pix ycc_predict(t_pix px, logic dir, logic pk);
        int p0, p1, p2, p3;
        int yy, cbv, crv, dcb, dcr;
        ryc_pkg::t_byte y8, cb8, cr8, r8, g8, b8;
        t_pix res;
        p0 = int'(px.b0);
        p1 = int'(px.b1);
        p2 = int'(px.b2);
        p3 = int'(px.b3);
        res.last = px.last;
        if (!dir) begin
            y8  = sat8((p0 * KYR + p1 * KYG + p2 * KYB + RoundAdd) >>> FracBits);
            cb8 = sat8(((-p0 * KCbR - p1 * KCbG + p2 * KHalf + RoundAdd) >>> FracBits)
                       + ChromaOff);
            cr8 = sat8(((p0 * KHalf - p1 * KCrG - p2 * KCrB + RoundAdd) >>> FracBits)
                       + ChromaOff);
            if (!pk) begin
                res.b0 = y8;
                res.b1 = cb8;
                res.b2 = cr8;
                res.b3 = px.b3;
            end else begin
                res.b0 = cb8;
                res.b1 = cr8;
                res.b2 = px.b3;
                res.b3 = y8;
            end
        end else begin
            if (!pk) begin
                yy = p0;
                cbv = p1;
                crv = p2;
                res.b3 = px.b3;
            end else begin
                yy = p3;
                cbv = p0;
                crv = p1;
                res.b3 = px.b2;
            end
            dcb = cbv - ChromaOff;
            dcr = crv - ChromaOff;
            r8 = sat8(yy + ((RoundAdd + dcr * KRCr) >>> FracBits));
            g8 = sat8(yy + ((RoundAdd - dcb * KGCb - dcr * KGCr) >>> FracBits));
            b8 = sat8(yy + ((RoundAdd + dcb * KBCb) >>> FracBits));
            res.b0 = r8;
            res.b1 = g8;
            res.b2 = b8;
        end
        return res;
    endfunction

    // extremes and the chroma midpoint come up more often than a flat draw gives
    function automatic ryc_pkg::t_byte pick_byte();
        case ($urandom_range(0, 9))
            0: return 8'd0;
            1: return 8'd255;
            2: return 8'd128;
            3: return ryc_pkg::t_byte'($urandom_range(120, 136));
            default: return ryc_pkg::t_byte'($urandom_range(0, 255));
        endcase
    endfunction

    task automatic push_pixel(t_pix px, logic typed, t_pix typed_res);
        pix_in.valid   <= 1'b1;
        pix_in.byte0   <= px.b0;
        pix_in.byte1   <= px.b1;
        pix_in.byte2   <= px.b2;
        pix_in.byte3   <= px.b3;
        pix_in.last_in <= px.last;
        @(posedge clk);
        while (!pix_in.ready) @(posedge clk);
        expect_q.push_back(typed ? typed_res : ycc_predict(px, dir_q, pk_q));
        pixels_sent++;
    endtask

    task automatic maybe_idle();
        if (!steady && $urandom_range(0, 3) == 0) begin
            pix_in.valid <= 1'b0;
            pix_in.byte0 <= ryc_pkg::t_byte'($urandom);
            pix_in.byte2 <= ryc_pkg::t_byte'($urandom);
            repeat ($urandom_range(1, 12)) @(posedge clk);
        end
    endtask

    task automatic drain();
        pix_in.valid <= 1'b0;
        while (expect_q.size() != 0) @(posedge clk);
    endtask

    task automatic cfg_write(logic [ryc_pkg::CfgIdxW-1:0] idx, logic val);
        cfg.valid     <= 1'b1;
        cfg.reg_index <= idx;
        cfg.wr_data   <= val;
        @(posedge clk);
        while (!cfg.ready) @(posedge clk);
        case (idx)
            ryc_pkg::REG_DIRECTION: dir_q = val;
            ryc_pkg::REG_PACKING:   pk_q = val;
            default: ;
        endcase
    endtask

    // unused indexes are written too and must change nothing
    task automatic apply_setting(logic dir, logic pk);
        drain();
        cfg_write(ryc_pkg::REG_DIRECTION, dir);
        cfg_write($urandom_range(0, 1) ? RegSpareHi : RegSpareLo, logic'($urandom_range(0, 1)));
        cfg_write(ryc_pkg::REG_PACKING, pk);
        cfg.valid <= 1'b0;
        settings_count++;
    endtask

    task automatic check_field(string name, int want, int got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk) begin : result_check
        t_pix got;
        t_pix want;
        if (rst_n && pix_out.valid && pix_out.ready) begin
            got = {pix_out.out0, pix_out.out1, pix_out.out2, pix_out.out3, pix_out.last_out};
            if (expect_q.size() == 0) begin
                $error("result item with nothing expected");
                fail_count++;
            end else begin
                want = expect_q.pop_front();
                check_field("out0", want.b0, got.b0);
                check_field("out1", want.b1, got.b1);
                check_field("out2", want.b2, got.b2);
                check_field("out3", want.b3, got.b3);
                check_field("last_out", want.last, got.last);
                results_seen++;
            end
        end
    end

    always @(posedge clk) begin
        cycle_count++;
        if (cycle_count > CycleLimit) begin
            $display("timeout after %0d cycles", cycle_count);
            $display("[FAIL] regression broken");
            $finish;
        end
    end

    initial begin : sink_pacer
        pix_out.ready <= 1'b0;
        @(posedge clk);
        while (!rst_n) @(posedge clk);
        forever begin
            if (hold_off_req) begin
                pix_out.ready <= 1'b0;
                repeat (HoldCycles) @(posedge clk);
                hold_off_req = 1'b0;
            end else if (!steady && $urandom_range(0, 3) == 0) begin
                pix_out.ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(posedge clk);
            end else begin
                pix_out.ready <= 1'b1;
                repeat ($urandom_range(1, 20)) @(posedge clk);
            end
        end
    end

    initial begin : stimulus
        t_pix px;
        logic dir;
        logic pk;
        pix_in.valid   <= 1'b0;
        pix_in.byte0   <= '0;
        pix_in.byte1   <= '0;
        pix_in.byte2   <= '0;
        pix_in.byte3   <= '0;
        pix_in.last_in <= 1'b0;
        cfg.valid      <= 1'b0;
        cfg.reg_index  <= ryc_pkg::REG_DIRECTION;
        cfg.wr_data    <= 1'b0;
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // first rows run on the reset setting
        foreach (DirVecs[i]) begin
            if (DirVecs[i].dir != dir_q || DirVecs[i].pk != pk_q) begin
                apply_setting(DirVecs[i].dir, DirVecs[i].pk);
            end
            maybe_idle();
            push_pixel(DirVecs[i].px, DirVecs[i].typed, DirVecs[i].res);
        end

        for (int ph = 0; ph < NumPhases; ph++) begin
            if (ph < 4) begin
                dir = logic'(ph & 1);
                pk  = logic'((ph >> 1) & 1);
            end else begin
                dir = logic'($urandom_range(0, 1));
                pk  = logic'($urandom_range(0, 1));
            end
            apply_setting(dir, pk);
            steady = (ph == 3 || ph == NumPhases - 1);
            // receiver holds off while the sender keeps offering
            if (ph == 2) begin
                hold_off_req = 1'b1;
            end
            for (int n = 0; n < PhaseItems; n++) begin
                if (n == PhaseItems / 2) begin
                    drain();
                end
                px.b0 = pick_byte();
                px.b1 = pick_byte();
                px.b2 = pick_byte();
                px.b3 = pick_byte();
                px.last = ($urandom_range(0, 7) == 0);
                maybe_idle();
                push_pixel(px, 1'b0, '0);
            end
        end

        drain();
        repeat (TailCycles) @(posedge clk);
        $display("%0d pixels over %0d register settings, %0d results compared",
                 pixels_sent, settings_count, results_seen);
        $display("both directions and packings, clamping, alpha routing, spare indexes");
        if (fail_count == 0) begin
            $display("[ OK ] regression clean");
        end else begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+rtl
rtl/ryc_pkg.sv
rtl/ryc_if.sv
rtl/rgb_ycbcr_pixel_converter.sv
tb/rgb_ycbcr_pixel_converter_tb.sv
